// ===== sv/hc_pkg.sv =====
// ----------------------------------------------------------------------------
// Header checker package
// Shared types, status codes, constants and the byte-wide CRC-32 update.
// ----------------------------------------------------------------------------
package hc_pkg;

    localparam int SPECIFIC_LEN_DEF = 6;
    localparam int SPECIFIC_LEN_MAX = 16;

    localparam int POS_W = 5;
    localparam int OUT_TDATA_W = 24;

    localparam logic [3:0][7:0] MAGIC = {8'h00, 8'h46, 8'h43, 8'h42};
    localparam logic [7:0] MAJOR_SUPPORTED = 8'd1;
    localparam logic [7:0] MINOR_SUPPORTED = 8'd0;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_MAGIC    = 3'd1,
        ST_BAD_MAJOR    = 3'd2,
        ST_BAD_MINOR    = 3'd3,
        ST_CRC_MISMATCH = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_header;
    } t_item;

    typedef struct packed {
        logic [POS_W-1:0] header_length;
        logic [7:0]       version_minor;
        logic [7:0]       version_major;
        t_status          status;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== sv/hc_in_reg.sv =====
// ----------------------------------------------------------------------------
// Header checker input register
// Holds one accepted item until the checking stage takes it.
// ----------------------------------------------------------------------------
module hc_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  hc_pkg::t_item i_item,
    input  logic          i_advance,
    output logic          o_ready,
    output logic          o_valid,
    output hc_pkg::t_item o_item
);

    logic          r_valid;
    hc_pkg::t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== sv/hc_check.sv =====
// ----------------------------------------------------------------------------
// Header checker core
// Tracks the position within a header, runs the CRC and decides the status.
// ----------------------------------------------------------------------------
module hc_check #(
    parameter int SPECIFIC_LEN = hc_pkg::SPECIFIC_LEN_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  hc_pkg::t_item   i_item,
    output logic            o_res_valid,
    output hc_pkg::t_result o_result
);

    localparam logic [hc_pkg::POS_W-1:0] CrcStart = hc_pkg::POS_W'(6 + SPECIFIC_LEN);
    localparam logic [hc_pkg::POS_W-1:0] TotalLen = hc_pkg::POS_W'(10 + SPECIFIC_LEN);

    logic [hc_pkg::POS_W-1:0] r_pos, n_pos;
    logic                     r_busy, n_busy;
    logic                     r_mm, n_mm;
    logic [31:0]              r_crc, n_crc;
    logic [31:0]              r_stored, n_stored;
    logic [7:0]               r_major, n_major;
    logic [7:0]               r_minor, n_minor;

    logic [hc_pkg::POS_W-1:0] pos_e;
    logic                     mm_e;
    logic [31:0]              crc_e;
    logic [31:0]              stored_e;
    logic [7:0]               major_e;
    logic [7:0]               minor_e;
    logic                     active;
    logic [7:0]               b;
    logic [1:0]               lane;

    always_comb begin
        b        = i_item.data_byte;
        active   = i_item.start_of_header || r_busy;
        pos_e    = i_item.start_of_header ? '0 : r_pos;
        mm_e     = i_item.start_of_header ? 1'b0 : r_mm;
        crc_e    = i_item.start_of_header ? hc_pkg::CRC_INIT : r_crc;
        stored_e = i_item.start_of_header ? 32'd0 : r_stored;
        major_e  = i_item.start_of_header ? 8'd0 : r_major;
        minor_e  = i_item.start_of_header ? 8'd0 : r_minor;
        lane     = 2'(pos_e - CrcStart);

        n_busy   = active;
        n_pos    = pos_e;
        n_mm     = mm_e;
        n_crc    = (pos_e < CrcStart) ? hc_pkg::crc_byte(crc_e, b) : crc_e;
        n_stored = stored_e;
        n_major  = major_e;
        n_minor  = minor_e;

        o_res_valid = 1'b0;
        o_result    = '{header_length: '0, version_minor: 8'd0, version_major: 8'd0,
                        status: hc_pkg::ST_OK};

        if (pos_e < 5'd4) begin
            n_mm = mm_e || (b != hc_pkg::MAGIC[pos_e[1:0]]);
            if (pos_e == 5'd3 && n_mm) begin
                o_res_valid          = 1'b1;
                o_result.status      = hc_pkg::ST_BAD_MAGIC;
            end
        end else if (pos_e == 5'd4) begin
            n_major = b;
        end else if (pos_e == 5'd5) begin
            n_minor = b;
            o_result.version_major = major_e;
            o_result.version_minor = b;
            if (major_e != hc_pkg::MAJOR_SUPPORTED) begin
                o_res_valid     = 1'b1;
                o_result.status = hc_pkg::ST_BAD_MAJOR;
            end else if (b != hc_pkg::MINOR_SUPPORTED) begin
                o_res_valid     = 1'b1;
                o_result.status = hc_pkg::ST_BAD_MINOR;
            end
        end else if (pos_e >= CrcStart && pos_e < TotalLen) begin
            n_stored = stored_e | ({24'd0, b} << {lane, 3'b000});
            if (pos_e == TotalLen - 5'd1) begin
                o_res_valid            = 1'b1;
                o_result.version_major = major_e;
                o_result.version_minor = minor_e;
                if (n_stored == ~crc_e) begin
                    o_result.status        = hc_pkg::ST_OK;
                    o_result.header_length = TotalLen;
                end else begin
                    o_result.status = hc_pkg::ST_CRC_MISMATCH;
                end
            end
        end

        if (!active) begin
            o_res_valid = 1'b0;
        end

        if (o_res_valid) begin
            n_busy = 1'b0;
        end else if (pos_e < TotalLen) begin
            n_pos = pos_e + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_busy   <= 1'b0;
            r_mm     <= 1'b0;
            r_crc    <= hc_pkg::CRC_INIT;
            r_stored <= 32'd0;
            r_major  <= 8'd0;
            r_minor  <= 8'd0;
        end else if (i_fire && active) begin
            r_pos    <= n_pos;
            r_busy   <= n_busy;
            r_mm     <= n_mm;
            r_crc    <= n_crc;
            r_stored <= n_stored;
            r_major  <= n_major;
            r_minor  <= n_minor;
        end
    end

endmodule

// ===== sv/hc_out_reg.sv =====
// ----------------------------------------------------------------------------
// Header checker output register
// Holds one status item until the downstream side takes it.
// ----------------------------------------------------------------------------
module hc_out_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  hc_pkg::t_result i_result,
    input  logic            i_ready,
    output logic            o_free,
    output logic            o_valid,
    output hc_pkg::t_result o_result
);

    logic            r_valid;
    hc_pkg::t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== sv/header_checker.sv =====
// ----------------------------------------------------------------------------
// Header checker
// Checks a byte-serial file header: magic, version and a CRC-32 over all bytes before it.
// ----------------------------------------------------------------------------
// Channel   Direction  tdata (low bit up)                      tuser
// s_axis    in         data_byte[7:0]                          start_of_header
// m_axis    out        status[2:0] version_major[10:3]         none
//                      version_minor[18:11] header_length[23:19]
//
// One byte is accepted per cycle while s_axis_tready is high; a status item is
// offered from the output register, which loads it when the checking stage
// takes the deciding byte from the input register. The CRC-32 is updated a
// whole byte per cycle between the input register and the output register
// while the checking stage advances. Reset is synchronous and active low and
// leaves the block idle until a start flag. A stalled status item holds back
// input only once the input register is also full.
// ----------------------------------------------------------------------------
module header_checker #(
    parameter int SPECIFIC_LEN = hc_pkg::SPECIFIC_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // data_byte
    input  logic                           s_axis_tuser,  // start_of_header
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [hc_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // status, major, minor, length
);

    localparam logic [hc_pkg::POS_W-1:0] TotalLen = hc_pkg::POS_W'(10 + SPECIFIC_LEN);

    hc_pkg::t_item   in_item;
    hc_pkg::t_item   stage_item;
    hc_pkg::t_result stage_result;
    hc_pkg::t_result out_result;
    logic            stage_valid;
    logic            res_valid;
    logic            out_free;
    logic            fire;

    assign in_item = '{data_byte: s_axis_tdata, start_of_header: s_axis_tuser};
    assign fire    = stage_valid && out_free;

    hc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_item    (in_item),
        .i_advance (out_free),
        .o_ready   (s_axis_tready),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    hc_check #(
        .SPECIFIC_LEN (SPECIFIC_LEN)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (stage_item),
        .o_res_valid (res_valid),
        .o_result    (stage_result)
    );

    hc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && res_valid),
        .i_result (stage_result),
        .i_ready  (m_axis_tready),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result)
    );

    assign m_axis_tdata = out_result;

    a_ok_length : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_result.status == hc_pkg::ST_OK)
            |-> (out_result.header_length == TotalLen))
        else $error("Successful header reported with the wrong length.");

    a_err_length : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_result.status != hc_pkg::ST_OK)
            |-> (out_result.header_length == '0))
        else $error("Failed header reported with a non-zero length.");

    a_magic_versions : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_result.status == hc_pkg::ST_BAD_MAGIC)
            |-> (out_result.version_major == 8'd0 && out_result.version_minor == 8'd0))
        else $error("Bad magic reported with version bytes set.");

    a_no_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !fire || !res_valid)
        else $error("Status item overwritten while the output is stalled.");

endmodule
